>>> rtl/core/plfc_pkg.sv
// plfc_pkg: shared constants, format codes and color conversion functions
// for the palette lookup / format convert block. No dependencies.
package plfc_pkg;

    localparam int PLFC_ENTRIES   = 256;
    localparam int PLFC_IDX_W     = 8;
    localparam int PLFC_COLOR_W   = 32;
    localparam int PLFC_FMT_W     = 4;

    typedef logic [PLFC_COLOR_W-1:0] t_color;
    typedef logic [PLFC_FMT_W-1:0]   t_fmt;

    localparam t_fmt FMT_RGB15BE  = 4'd0;
    localparam t_fmt FMT_BGR15BE  = 4'd1;
    localparam t_fmt FMT_RGB15LE  = 4'd2;
    localparam t_fmt FMT_BGR15LE  = 4'd3;
    localparam t_fmt FMT_RGB16BE  = 4'd4;
    localparam t_fmt FMT_BGR16BE  = 4'd5;
    localparam t_fmt FMT_RGB16LE  = 4'd6;
    localparam t_fmt FMT_BGR16LE  = 4'd7;
    localparam t_fmt FMT_RGB24    = 4'd8;
    localparam t_fmt FMT_BGR24    = 4'd9;
    localparam t_fmt FMT_ARGB32BE = 4'd10;
    localparam t_fmt FMT_ABGR32BE = 4'd11;
    localparam t_fmt FMT_ARGB32LE = 4'd12;
    localparam t_fmt FMT_ABGR32LE = 4'd13;

    localparam logic MODE_CONVERT = 1'b0;
    localparam logic MODE_WRITE   = 1'b1;

    function automatic t_color swap_rb(input t_color c);
        return {c[31:24], c[7:0], c[15:8], c[23:16]};
    endfunction

    function automatic t_color to15(input t_color c);
        return {17'd0, c[23:19], c[15:11], c[7:3]};
    endfunction

    function automatic t_color to16(input t_color c);
        return {16'd0, c[23:19], c[15:10], c[7:3]};
    endfunction

    function automatic t_color bswap16(input t_color v);
        return {16'd0, v[7:0], v[15:8]};
    endfunction

    function automatic t_color bswap32(input t_color v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic t_color convert(input t_color c, input t_fmt fmt);
        t_color res;
        case (fmt)
            FMT_RGB15BE:  res = to15(c);
            FMT_BGR15BE:  res = to15(swap_rb(c));
            FMT_RGB15LE:  res = bswap16(to15(c));
            FMT_BGR15LE:  res = bswap16(to15(swap_rb(c)));
            FMT_RGB16BE:  res = to16(c);
            FMT_BGR16BE:  res = to16(swap_rb(c));
            FMT_RGB16LE:  res = bswap16(to16(c));
            FMT_BGR16LE:  res = bswap16(to16(swap_rb(c)));
            FMT_RGB24:    res = {8'd0, c[23:0]};
            FMT_BGR24:    res = {8'd0, c[7:0], c[15:8], c[23:16]};
            FMT_ARGB32BE: res = c;
            FMT_ABGR32BE: res = swap_rb(c);
            FMT_ARGB32LE: res = bswap32(c);
            FMT_ABGR32LE: res = bswap32(swap_rb(c));
            default:      res = '0;
        endcase
        return res;
    endfunction

endpackage

>>> rtl/core/palette_lookup_format_convert.sv
// palette_lookup_format_convert: top level, indexed color to direct color.
// Uses plfc_pkg and plfc_ram.
//
// Takes one item per clock, back-pressured by m_axis_tready, and delivers one
// converted pixel per clock: a lookup passes the palette RAM read, then format
// conversion into the output register. Items with tuser high write tdata[39:8]
// into palette entry tdata[7:0] and give no output; items with tuser low look up
// that entry and emit it in the format held in the format register, written
// through i_cfg_we / i_cfg_wdata; the user must write it only while idle, which
// the block does not enforce. Indexes at or above PALETTE_ENTRIES are ignored on
// write and read as zero. Reading an entry never written gives an undefined pixel.
module palette_lookup_format_convert
    import plfc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PLFC_ENTRIES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [PLFC_FMT_W-1:0]                i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [PLFC_IDX_W+PLFC_COLOR_W-1:0]   s_axis_tdata,  // index, entry_color
    input  logic                                 s_axis_tuser,  // mode
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [PLFC_COLOR_W-1:0]              m_axis_tdata   // pixel_out
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    t_fmt                  r_fmt;
    logic                  r_s1_vld;
    logic                  r_s1_oor;
    logic                  r_out_vld;
    t_color                r_out_data;

    logic [PLFC_IDX_W-1:0] s_idx;
    t_color                s_color;
    logic                  s_acc;
    logic                  s_in_range;
    logic                  ram_we;
    logic                  ram_re;
    t_color                ram_rdata;
    logic                  s1_adv;

    assign s_idx      = s_axis_tdata[PLFC_IDX_W-1:0];
    assign s_color    = s_axis_tdata[PLFC_IDX_W+PLFC_COLOR_W-1:PLFC_IDX_W];
    assign s_in_range = {1'b0, s_idx} < (PLFC_IDX_W+1)'(PALETTE_ENTRIES);

    assign s1_adv        = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_s1_vld || s1_adv;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign ram_we        = s_acc && (s_axis_tuser == MODE_WRITE) && s_in_range;
    assign ram_re        = s_acc && (s_axis_tuser == MODE_CONVERT);

    plfc_ram #(
        .WIDTH (PLFC_COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (s_idx[AW-1:0]),
        .i_wdata (s_color),
        .i_re    (ram_re),
        .i_raddr (s_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_RGB15BE;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (ram_re) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_s1_oor <= !s_in_range;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_out_data <= r_s1_oor ? '0 : convert(ram_rdata, r_fmt);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_adv |=> r_s1_vld)
        else $error("read stage lost an item while stalled");

    a_rd_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> r_s1_vld)
        else $error("convert item did not reach read stage");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("palette read and write from one item");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && r_s1_oor && s1_adv |=> m_axis_tvalid && (m_axis_tdata == '0))
        else $error("out of range index gave nonzero pixel");

    a_bad_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && s1_adv && (r_fmt > FMT_ABGR32LE)
        |=> m_axis_tdata == '0)
        else $error("undefined format gave nonzero pixel");

endmodule

>>> rtl/core/plfc_ram.sv
// plfc_ram: generic simple dual-port RAM, one write and one read port,
// registered read data. No dependencies.
module plfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
